// ===== sv/prtg_pkg.sv =====
package prtg_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_FLIP_MASK  = 2'd0;
  localparam logic [1:0] REG_PHASE_MASK = 2'd1;
  localparam logic [1:0] REG_COS_HALF   = 2'd2;
  localparam logic [1:0] REG_SIN_HALF   = 2'd3;

  localparam logic signed [15:0] COS_RESET = 16'sh7FFF;
  localparam logic signed [15:0] SIN_RESET = 16'sh0000;

  // Configuration as seen by the pipeline, masks already cut to the qubit count
  typedef struct packed {
    logic [63:0]        flip_mask;
    logic [63:0]        phase_mask;
    logic signed [15:0] cos_half;
    logic signed [15:0] sin_half;
  } cfg_t;

  // Stage 1 payload: term with its Pauli phase code
  typedef struct packed {
    logic [63:0]        basis;
    logic [63:0]        flip_basis;
    logic signed [15:0] amp_re;
    logic signed [15:0] amp_im;
    logic [1:0]         k;
  } s1_t;

  // Stage 2 payload: exact Q2.30 products
  typedef struct packed {
    logic [63:0]        basis;
    logic [63:0]        flip_basis;
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic signed [31:0] s_re;
    logic signed [31:0] s_im;
    logic [1:0]         k;
  } s2_t;

  // Q2.30 to Q1.15, round half up, saturate
  function automatic logic signed [15:0] round_sat(input logic signed [31:0] p);
    logic signed [32:0] t;
    logic signed [17:0] r;
    t = {p[31], p} + 33'sd16384;
    r = 18'(t >>> 15);
    if (r > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return r[15:0];
    end
  endfunction

endpackage

// ===== sv/prtg_phase.sv =====
// Stage 1: flipped basis and phase code k = 3 + nY + 2*parity (mod 4)
module prtg_phase (
  input  logic               clk,
  input  logic               rst_n,
  input  prtg_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_basis,
  input  logic signed [15:0] in_re,
  input  logic signed [15:0] in_im,
  output logic               s1_valid,
  input  logic               s1_ready,
  output prtg_pkg::s1_t      s1
);

  logic          valid_r;
  prtg_pkg::s1_t s1_r;
  prtg_pkg::s1_t s1_nxt;
  logic [6:0]    ny_cnt;
  logic          parity;

  assign in_ready = !valid_r || s1_ready;

  // Phase code from the Y count and the Z parity of the basis
  always_comb begin
    ny_cnt            = 7'($countones(cfg.flip_mask & cfg.phase_mask));
    parity            = ^(in_basis & cfg.phase_mask);
    s1_nxt.basis      = in_basis;
    s1_nxt.flip_basis = in_basis ^ cfg.flip_mask;
    s1_nxt.amp_re     = in_re;
    s1_nxt.amp_im     = in_im;
    s1_nxt.k          = 2'd3 + ny_cnt[1:0] + {parity, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1       = s1_r;

endmodule

// ===== sv/prtg_mul.sv =====
// Stage 2: four 16x16 products, registered
module prtg_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  prtg_pkg::cfg_t cfg,
  input  logic           s1_valid,
  output logic           s1_ready,
  input  prtg_pkg::s1_t  s1,
  output logic           s2_valid,
  input  logic           s2_ready,
  output prtg_pkg::s2_t  s2
);

  logic          valid_r;
  prtg_pkg::s2_t s2_r;
  prtg_pkg::s2_t s2_nxt;

  assign s1_ready = !valid_r || s2_ready;

  always_comb begin
    s2_nxt.basis      = s1.basis;
    s2_nxt.flip_basis = s1.flip_basis;
    s2_nxt.c_re       = cfg.cos_half * s1.amp_re;
    s2_nxt.c_im       = cfg.cos_half * s1.amp_im;
    s2_nxt.s_re       = cfg.sin_half * s1.amp_re;
    s2_nxt.s_im       = cfg.sin_half * s1.amp_im;
    s2_nxt.k          = s1.k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_ready) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = valid_r;
  assign s2       = s2_r;

endmodule

// ===== sv/prtg_emit.sv =====
// Stage 3: apply i^k, round both terms, then send cosine beat and Pauli beat
module prtg_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s2_valid,
  output logic               s2_ready,
  input  prtg_pkg::s2_t      s2,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_basis,
  output logic signed [15:0] out_re,
  output logic signed [15:0] out_im,
  output logic               out_last
);

  logic               valid_r;
  logic               phase_r;
  logic [63:0]        basis_r;
  logic [63:0]        fbasis_r;
  logic signed [15:0] cre_r, cim_r, pre_r, pim_r;
  logic signed [31:0] rre, rim;
  logic               load;

  // Pair register is free when empty or its Pauli beat leaves now
  assign s2_ready = !valid_r || (phase_r && out_ready);
  assign load     = s2_ready && s2_valid;

  // Multiply by i^k exactly: swap and negate
  always_comb begin
    case (s2.k)
      2'd0: begin
        rre = s2.s_re;
        rim = s2.s_im;
      end
      2'd1: begin
        rre = -s2.s_im;
        rim = s2.s_re;
      end
      2'd2: begin
        rre = -s2.s_re;
        rim = -s2.s_im;
      end
      default: begin
        rre = s2.s_im;
        rim = -s2.s_re;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      phase_r <= 1'b0;
    end else if (valid_r && out_ready) begin
      valid_r <= !phase_r;
      phase_r <= !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      basis_r  <= s2.basis;
      fbasis_r <= s2.flip_basis;
      cre_r    <= prtg_pkg::round_sat(s2.c_re);
      cim_r    <= prtg_pkg::round_sat(s2.c_im);
      pre_r    <= prtg_pkg::round_sat(rre);
      pim_r    <= prtg_pkg::round_sat(rim);
    end
  end

  assign out_valid = valid_r;
  assign out_last  = phase_r;
  assign out_basis = phase_r ? fbasis_r : basis_r;
  assign out_re    = phase_r ? pre_r : cre_r;
  assign out_im    = phase_r ? pim_r : cim_r;

  // Cosine beat taken: its Pauli beat follows at once
  a_pauli_follows: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !phase_r && out_ready |=> valid_r && phase_r)
    else $error("Pauli beat missing after cosine beat");

  // A held pair keeps its phase under stall
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(phase_r))
    else $error("output pair changed under stall");

  // A new pair never overwrites an unsent cosine beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !phase_r |-> !s2_ready)
    else $error("pair register accepts while cosine beat pending");

endmodule

// ===== sv/pauli_rotation_term_generator.sv =====
// Channel | Dir | Beat fields (low bit up)
// in_     | in  | tdata: basis_index[63:0], amp_re[79:64], amp_im[95:80]
// out_    | out | tdata: out_basis[63:0], out_re[79:64], out_im[95:80];
//         |     | tlast: is_flipped_term
// cfg_    | in  | cfg_index (0 flip, 1 phase, 2 cos, 3 sin), cfg_data
//
// Three register stages (phase code, products, round/pair), then two output
// beats per term: cosine beat, then Pauli beat with tlast set.
// An input term passes the phase, product and pair registers before its cosine
// beat; a new term enters the pair register as the last Pauli beat leaves.
// rst_n is synchronous; it clears valid bits and loads register reset values.
// Stalls on out_ back up stage by stage; nothing is lost or repeated.
module pauli_rotation_term_generator #(
  parameter int QUBIT_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // basis_index, amp_re, amp_im
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // out_basis, out_re, out_im
  output logic        out_tlast,  // is_flipped_term
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [QUBIT_COUNT-1:0] flip_r;
  logic [QUBIT_COUNT-1:0] phase_r;
  logic signed [15:0]     cos_r;
  logic signed [15:0]     sin_r;
  prtg_pkg::cfg_t         cfg;

  logic               s1_valid, s1_ready;
  prtg_pkg::s1_t      s1;
  logic               s2_valid, s2_ready;
  prtg_pkg::s2_t      s2;
  logic [63:0]        o_basis;
  logic signed [15:0] o_re, o_im;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r  <= '0;
      phase_r <= '0;
      cos_r   <= prtg_pkg::COS_RESET;
      sin_r   <= prtg_pkg::SIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        prtg_pkg::REG_FLIP_MASK:  flip_r  <= cfg_data[QUBIT_COUNT-1:0];
        prtg_pkg::REG_PHASE_MASK: phase_r <= cfg_data[QUBIT_COUNT-1:0];
        prtg_pkg::REG_COS_HALF:   cos_r   <= cfg_data[15:0];
        prtg_pkg::REG_SIN_HALF:   sin_r   <= cfg_data[15:0];
      endcase
    end
  end

  assign cfg.flip_mask  = 64'(flip_r);
  assign cfg.phase_mask = 64'(phase_r);
  assign cfg.cos_half   = cos_r;
  assign cfg.sin_half   = sin_r;

  prtg_phase u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_basis (in_tdata[63:0]),
    .in_re    (in_tdata[79:64]),
    .in_im    (in_tdata[95:80]),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  prtg_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  prtg_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2        (s2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_basis (o_basis),
    .out_re    (o_re),
    .out_im    (o_im),
    .out_last  (out_tlast)
  );

  assign out_tdata = {o_im, o_re, o_basis};

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUBIT_COUNT  = 64;
  localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;     // settle time after the last result beat
  localparam int MAX_PRINTS   = 100;

  typedef struct {
    logic [63:0]        basis;
    logic signed [15:0] re;
    logic signed [15:0] im;
  } amp_term_t;

  typedef struct {
    logic [63:0]        basis;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               flipped;
  } rot_term_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;    // basis_index, amp_re, amp_im
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;          // out_basis, out_re, out_im
  logic        out_tlast;          // is_flipped_term
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = prtg_pkg::REG_FLIP_MASK;
  logic [63:0] cfg_data   = '0;

  // Predictor copy of the rotation registers
  logic [63:0]        flip_mask_q  = '0;
  logic [63:0]        phase_mask_q = '0;
  logic signed [15:0] cos_q        = prtg_pkg::COS_RESET;
  logic signed [15:0] sin_q        = prtg_pkg::SIN_RESET;

  amp_term_t pending_terms[$];
  rot_term_t expected_terms[$];

  int queued_terms   = 0;
  int accepted_terms = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  int in_max_wait    = 0;
  int out_max_wait   = 0;
  int in_wait        = 0;
  int out_wait       = 0;
  int hold_left      = 0;
  int hold_requests  = 0;
  int holds_done     = 0;
  logic in_hs  = 1'b0;  // input beat taken at the last rising edge
  logic out_hs = 1'b0;  // result beat taken at the last rising edge

  pauli_rotation_term_generator #(.QUBIT_COUNT(QUBIT_COUNT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q2.30 to Q1.15: add half an LSB, floor, saturate
  function automatic logic signed [15:0] q15_round(input longint p);
    longint r;
    r = (p + 16384) >>> 15;
    if (r > 32767) return 16'sh7FFF;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  // Expected cosine and Pauli terms for one input term
  function automatic void rotate_term(input amp_term_t t);
    logic [63:0] qm;
    logic [63:0] fm;
    logic [63:0] pm;
    longint      c;
    longint      s;
    longint      ar;
    longint      ai;
    longint      pre;
    longint      pim;
    longint      rre;
    longint      rim;
    longint      tmp;
    int          k;
    rot_term_t   cos_t;
    rot_term_t   pauli_t;
    qm = (QUBIT_COUNT >= 64) ? '1 : ((64'd1 << QUBIT_COUNT) - 64'd1);
    fm = flip_mask_q & qm;
    pm = phase_mask_q & qm;
    c  = cos_q;
    s  = sin_q;
    ar = t.re;
    ai = t.im;
    cos_t.basis   = t.basis;
    cos_t.re      = q15_round(c * ar);
    cos_t.im      = q15_round(c * ai);
    cos_t.flipped = 1'b0;
    // factor -i * i^nY * (-1)^parity, as a power of i
    pre = s * ar;
    pim = s * ai;
    k = (3 + $countones(fm & pm) + 2 * ($countones(t.basis & pm) & 1)) & 3;
    rre = pre;
    rim = pim;
    if (k[0]) begin
      tmp = rre;
      rre = -rim;
      rim = tmp;
    end
    if (k[1]) begin
      rre = -rre;
      rim = -rim;
    end
    pauli_t.basis   = t.basis ^ fm;
    pauli_t.re      = q15_round(rre);
    pauli_t.im      = q15_round(rim);
    pauli_t.flipped = 1'b1;
    expected_terms.push_back(cos_t);
    expected_terms.push_back(pauli_t);
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Input driver: one term per beat, random gap after each accepted beat
  always @(negedge clk) begin
    amp_term_t t;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait   <= 0;
    end else if (in_tvalid && !in_hs) begin
      // beat still on offer
    end else if (in_wait > 0) begin
      in_tvalid <= 1'b0;
      in_wait   <= in_wait - 1;
    end else if (pending_terms.size() > 0) begin
      t = pending_terms.pop_front();
      in_tdata  <= {t.im, t.re, t.basis};
      in_tvalid <= 1'b1;
      in_wait   <= $urandom_range(0, in_max_wait);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver: random ready gaps, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   <= 0;
      hold_left  <= 0;
    end else if (holds_done != hold_requests) begin
      holds_done <= hold_requests;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (out_tready && !out_hs) begin
      // keep ready until a beat arrives
    end else if (out_wait > 0) begin
      out_tready <= 1'b0;
      out_wait   <= out_wait - 1;
    end else begin
      out_tready <= 1'b1;
      out_wait   <= $urandom_range(0, out_max_wait);
    end
  end

  // Monitor: predict on input beats, check result beats in order
  always @(posedge clk) begin
    amp_term_t t;
    rot_term_t want;
    in_hs  <= rst_n && in_tvalid && in_tready;
    out_hs <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      t.basis = in_tdata[63:0];
      t.re    = in_tdata[79:64];
      t.im    = in_tdata[95:80];
      rotate_term(t);
      accepted_terms++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_terms.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[63:0], '0);
      end else begin
        want = expected_terms.pop_front();
        if (out_tdata[63:0] !== want.basis)
          report_mismatch("out_basis", out_tdata[63:0], want.basis);
        if (out_tdata[79:64] !== want.re)
          report_mismatch("out_re", 64'(out_tdata[79:64]), 64'(want.re));
        if (out_tdata[95:80] !== want.im)
          report_mismatch("out_im", 64'(out_tdata[95:80]), 64'(want.im));
        if (out_tlast !== want.flipped)
          report_mismatch("is_flipped_term", 64'(out_tlast), 64'(want.flipped));
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $realtime, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_term(input logic [63:0] basis, input logic [15:0] re,
                            input logic [15:0] im);
    amp_term_t t;
    t.basis = basis;
    t.re    = re;
    t.im    = im;
    pending_terms.push_back(t);
    queued_terms++;
  endtask

  task automatic wait_drained();
    while (accepted_terms != queued_terms || expected_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      prtg_pkg::REG_FLIP_MASK:  flip_mask_q  = val;
      prtg_pkg::REG_PHASE_MASK: phase_mask_q = val;
      prtg_pkg::REG_COS_HALF:   cos_q        = val[15:0];
      prtg_pkg::REG_SIN_HALF:   sin_q        = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Angle registers get junk in the unused upper bits
  task automatic set_rotation(input logic [63:0] fm, input logic [63:0] pm,
                              input logic [15:0] c, input logic [15:0] s);
    write_reg(prtg_pkg::REG_FLIP_MASK, fm);
    write_reg(prtg_pkg::REG_PHASE_MASK, pm);
    write_reg(prtg_pkg::REG_COS_HALF, {$urandom, 16'($urandom), c});
    write_reg(prtg_pkg::REG_SIN_HALF, {$urandom, 16'($urandom), s});
  endtask

  function automatic logic [63:0] pick_mask();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] pick_q15();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_amp();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero sine, Pauli term carries zero amplitude
    queue_term(64'h0, 16'h7FFF, 16'h8000);
    queue_term('1, 16'h8000, 16'h7FFF);
    queue_term(64'h5555_5555_5555_5555, 16'h0000, 16'h0000);
    queue_term(64'hAAAA_AAAA_AAAA_AAAA, 16'h0001, 16'hFFFF);
    queue_term({$urandom, $urandom}, 16'hFFFF, 16'h0001);
    wait_drained();

    // Full-scale negative angle terms, all qubits Y
    set_rotation('1, '1, 16'h8000, 16'h8000);
    queue_term(64'h0, 16'h8000, 16'h8000);
    queue_term('1, 16'h8000, 16'h7FFF);
    queue_term(64'h8000_0000_0000_0001, 16'h7FFF, 16'h7FFF);
    queue_term(64'h1, 16'h4000, 16'hC000);
    queue_term(64'h3, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // Mixed X/Y/Z string, basis values covering both Z parities (phase codes 3 and 1)
    set_rotation(64'h00FF_00FF_00FF_00FF, 64'h0F0F_0F0F_0F0F_0F0F, 16'h7FFF, 16'h7FFF);
    queue_term(64'h0, 16'h7FFF, 16'h8000);
    queue_term(64'h1, 16'h7FFF, 16'h8000);
    queue_term(64'h3, 16'h1234, 16'hEDCC);
    queue_term(64'h7, 16'h8000, 16'h0001);
    queue_term(64'h0F0F_0000_0000_0000, 16'h4000, 16'h4000);
    queue_term(64'hF0F0_F0F0_F0F0_F0F1, 16'hC000, 16'h3FFF);
    queue_term('1, 16'h0001, 16'h0000);
    wait_drained();

    // Random settings with random terms, idling mode varying per phase
    for (int ph = 0; ph < 9; ph++) begin
      set_rotation(pick_mask(), pick_mask(), pick_q15(), pick_q15());
      in_max_wait  = (ph % 3 == 0) ? 0 : 11;
      out_max_wait = (ph % 3 == 1) ? 0 : 11;
      repeat (120) queue_term({$urandom, $urandom}, pick_amp(), pick_amp());
      wait_drained();
    end

    // Back-pressure: full-rate sender against a long receiver hold-off
    set_rotation({$urandom, $urandom}, {$urandom, $urandom}, pick_q15(), pick_q15());
    in_max_wait  = 0;
    out_max_wait = 0;
    hold_requests++;
    repeat (200) queue_term({$urandom, $urandom}, pick_amp(), pick_amp());
    wait_drained();

    if (mismatches == 0 && expected_terms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/prtg_pkg.sv
sv/prtg_phase.sv
sv/prtg_mul.sv
sv/prtg_emit.sv
sv/pauli_rotation_term_generator.sv
tb/tb.sv
